FILE: src/alpha_premultiply_converter_core_assert.svh
// Assertion macros shared by the converter RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef ALPHA_PREMULTIPLY_CONVERTER_CORE_ASSERT_SVH
`define ALPHA_PREMULTIPLY_CONVERTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked outside reset only.
`define APC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define APC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define APC_ASSERT(lbl, prop, msg)
`define APC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/apc_pkg.sv
// Types, constants and the divide step function of the alpha converter.
// No dependencies; used by alpha_premultiply_converter_core.
package apc_pkg;

  localparam int unsigned NumCh         = 3;
  localparam int unsigned NumW          = 16;
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned DivStages     = NumW / StepsPerStage;

  typedef logic [7:0] chan_t;

  localparam chan_t FullAlpha = 8'hFF;
  localparam chan_t RoundHalf = 8'd127;

  typedef enum logic {
    FUNC_PREMUL   = 1'b0,
    FUNC_UNPREMUL = 1'b1
  } func_e;

  // One color lane of the restoring divider: the numerator shifts out at the
  // top while quotient bits shift in at the bottom.
  typedef struct packed {
    logic [NumW-1:0] num;
    chan_t           rem;
  } lane_t;

  typedef struct packed {
    lane_t [NumCh-1:0] lane;
    chan_t             div;
    logic              bypass;
    chan_t [NumCh-1:0] color;
    chan_t             alpha;
  } slot_t;

  function automatic lane_t div_steps(lane_t l, chan_t d);
    lane_t      r;
    logic [8:0] part;
    r = l;
    for (int i = 0; i < StepsPerStage; i++) begin
      part = {r.rem, r.num[NumW-1]};
      if (part >= {1'b0, d}) begin
        r.rem = chan_t'(part - {1'b0, d});
        r.num = {r.num[NumW-2:0], 1'b1};
      end else begin
        r.rem = part[7:0];
        r.num = {r.num[NumW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

FILE: src/alpha_premultiply_converter_core.sv
// Request path: entry register st_q[0], divide stages st_q[1] to st_q[4], output register.
// Throughput: one pixel per clock when not stalled; the rate is set by the
// divide pipeline, four stages that each resolve four quotient bits for all
// three colors. Under a stall, a full stage holds only if all later ones are full;
// empty stages still fill. Reset clears all valid bits; data registers are not reset.
// Depends on apc_pkg and alpha_premultiply_converter_core_assert.svh.
`include "alpha_premultiply_converter_core_assert.svh"

module alpha_premultiply_converter_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          func_i,
  input  apc_pkg::chan_t red_in_i,
  input  apc_pkg::chan_t green_in_i,
  input  apc_pkg::chan_t blue_in_i,
  input  apc_pkg::chan_t alpha_in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output apc_pkg::chan_t red_out_o,
  output apc_pkg::chan_t green_out_o,
  output apc_pkg::chan_t blue_out_o,
  output apc_pkg::chan_t alpha_out_o
);
  import apc_pkg::*;

  slot_t              st_q [DivStages+1];
  slot_t              step_d [1:DivStages];
  logic [DivStages:0] vld_q;
  logic [DivStages:0] rdy;
  logic               out_rdy;
  logic               out_vld_q;
  chan_t [NumCh-1:0]  out_color_q;
  chan_t              out_alpha_q;
  slot_t              entry_d;
  chan_t [NumCh-1:0]  in_color;
  chan_t [NumCh-1:0]  res_d;
  func_e              func;
  logic               rem_ok;

  assign func     = func_e'(func_i);
  assign in_color = {blue_in_i, green_in_i, red_in_i};

  // A stage may load when it is empty or its successor loads this cycle.
  always_comb begin
    out_rdy        = !out_vld_q || !out_stall_i;
    rdy[DivStages] = !vld_q[DivStages] || out_rdy;
    for (int k = DivStages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[0];

  // Entry stage: build each color's numerator and the divisor shared by all colors.
  always_comb begin
    logic [NumW-1:0] prod;
    entry_d       = '0;
    entry_d.color = in_color;
    entry_d.alpha = alpha_in_i;
    if (func == FUNC_UNPREMUL) begin
      entry_d.bypass = (alpha_in_i == '0) || (alpha_in_i == FullAlpha);
      // Alpha zero bypasses; keep a nonzero divisor so the lanes stay sane.
      entry_d.div    = (alpha_in_i == '0) ? FullAlpha : alpha_in_i;
    end else begin
      entry_d.bypass = (alpha_in_i == FullAlpha);
      entry_d.div    = FullAlpha;
    end
    for (int ch = 0; ch < NumCh; ch++) begin
      if (func == FUNC_UNPREMUL) begin
        prod = {in_color[ch], 8'h00} - {8'h00, in_color[ch]}
               + {9'h000, alpha_in_i[7:1]};
      end else begin
        prod = ({8'h00, in_color[ch]} * {8'h00, alpha_in_i}) + {8'h00, RoundHalf};
      end
      entry_d.lane[ch].num = prod;
      entry_d.lane[ch].rem = '0;
    end
  end

  // Next content of each divide stage: the slot moves on with four more quotient bits.
  always_comb begin
    for (int k = 1; k <= DivStages; k++) begin
      step_d[k] = st_q[k-1];
      for (int ch = 0; ch < NumCh; ch++) begin
        step_d[k].lane[ch] = div_steps(st_q[k-1].lane[ch], st_q[k-1].div);
      end
    end
  end

  // Quotients above 255 only arise when a color exceeds its alpha.
  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      if (st_q[DivStages].bypass) begin
        res_d[ch] = st_q[DivStages].color[ch];
      end else if (st_q[DivStages].lane[ch].num[NumW-1:8] != '0) begin
        res_d[ch] = FullAlpha;
      end else begin
        res_d[ch] = st_q[DivStages].lane[ch].num[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= DivStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
      if (out_rdy) begin
        out_vld_q <= vld_q[DivStages];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      st_q[0] <= entry_d;
    end
    for (int k = 1; k <= DivStages; k++) begin
      if (rdy[k] && vld_q[k-1]) begin
        st_q[k] <= step_d[k];
      end
    end
    if (out_rdy && vld_q[DivStages]) begin
      out_color_q <= res_d;
      out_alpha_q <= st_q[DivStages].alpha;
    end
  end

  assign out_valid_o = out_vld_q;
  assign red_out_o   = out_color_q[0];
  assign green_out_o = out_color_q[1];
  assign blue_out_o  = out_color_q[2];
  assign alpha_out_o = out_alpha_q;

  assign rem_ok = (st_q[DivStages].lane[0].rem < st_q[DivStages].div) &&
                  (st_q[DivStages].lane[1].rem < st_q[DivStages].div) &&
                  (st_q[DivStages].lane[2].rem < st_q[DivStages].div);

  `APC_ASSERT(a_no_stall_when_free, !out_stall_i |-> !in_stall_o, "stall without backpressure")
  `APC_ASSERT(a_rem_below_div, vld_q[DivStages] |-> rem_ok, "divider remainder out of range")
  `APC_ASSERT(a_last_stage_holds, out_valid_o && out_stall_i && vld_q[DivStages] |=> vld_q[DivStages], "request dropped under stall")
  `APC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o && (vld_q == '0), "valid set during reset")

endmodule
